// ===== sv/cvfp_pkg.sv =====
`timescale 1ns / 1ps
package cvfp_pkg;

	// Field width of every input and result item
	localparam int unsigned FIELD_W = 32;

	// pi/4 with 62 fractional bits
	localparam logic [63:0] PI_QUARTER_Q62 = 64'h3243_F6A8_885A_308D;

	// round(atan(2^-i) * 2^frac) for 0 <= i <= 30; evaluated at elaboration only.
	// For i >= 1 the arctangent series is summed at 62 fractional bits, then rounded.
	function automatic logic [63:0] atan_entry(int unsigned i, int unsigned frac);
		logic [63:0] acc;
		logic [63:0] term;
		int unsigned p;
		logic        done;
		acc  = '0;
		done = 1'b0;
		if (i == 0) begin
			acc = PI_QUARTER_Q62;
		end else begin
			for (int unsigned k = 0; k < 64; k++) begin
				p = i * (2 * k + 1);
				if (p > 62) begin
					done = 1'b1;
				end
				if (!done) begin
					term = (64'd1 << (62 - p)) / 64'(2 * k + 1);
					if (k[0]) begin
						acc = acc - term;
					end else begin
						acc = acc + term;
					end
				end
			end
		end
		return (acc + (64'd1 << (61 - frac))) >> (62 - frac);
	endfunction

endpackage

// ===== sv/cvfp_vec_if.sv =====
`timescale 1ns / 1ps
interface cvfp_vec_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [cvfp_pkg::FIELD_W-1:0] x_in;
	logic signed [cvfp_pkg::FIELD_W-1:0] y_in;

	modport source (output valid, output x_in, output y_in, input ready);
	modport sink (input valid, input x_in, input y_in, output ready);
endinterface

// ===== sv/cvfp_res_if.sv =====
`timescale 1ns / 1ps
interface cvfp_res_if;
	logic                                     valid;
	logic                                     ready;
	logic signed [cvfp_pkg::FIELD_W-1:0] x_out;
	logic signed [cvfp_pkg::FIELD_W-1:0] y_out;
	logic signed [cvfp_pkg::FIELD_W-1:0] angle_out;

	modport source (output valid, output x_out, output y_out, output angle_out, input ready);
	modport sink (input valid, input x_out, input y_out, input angle_out, output ready);
endinterface

// ===== sv/cordic_vectoring_fixed_point_unit.sv =====
`timescale 1ns / 1ps
// CORDIC vectoring unit: takes a vector (x_in, y_in) on the vec channel and
// returns the gain-scaled magnitude x_out, the residual y_out and the angle
// angle_out (units of 2^-ANGLE_FRAC_BITS radian) on the res channel.
// Both channels use valid/ready; an item moves when both are high.
// The datapath is a row of ITERATIONS cells, one micro-rotation each, every
// cell holding one item in its own register and passing it on when the next cell takes it.
// Each accepted item passes through the ITERATIONS cell registers (15 by default) in order before res.valid.
// Throughput: one item per cycle while res.ready is high; each cell takes a new item whenever it is
// empty or its neighbor takes the one it holds.
// When res.ready is low, the last cell holds its result and items pile up
// behind it; vec.ready drops only once every cell is full.
// Reset clears all cell valid flags; no result is pending after reset.
// Arithmetic wraps at DATA_WIDTH bits; results are sign-extended or
// truncated to the 32-bit fields.
module cordic_vectoring_fixed_point_unit #(
	parameter int unsigned ITERATIONS      = 15,
	parameter int unsigned DATA_WIDTH      = 32,
	parameter int unsigned ANGLE_FRAC_BITS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	cvfp_vec_if.sink   vec,
	cvfp_res_if.source res
);
	import cvfp_pkg::*;

	logic                         valid_c [0:ITERATIONS];
	logic                         ready_c [0:ITERATIONS];
	logic signed [DATA_WIDTH-1:0] x_c     [0:ITERATIONS];
	logic signed [DATA_WIDTH-1:0] y_c     [0:ITERATIONS];
	logic signed [DATA_WIDTH-1:0] z_c     [0:ITERATIONS];

	logic signed [63:0] x_in64, y_in64;
	logic signed [63:0] x_out64, y_out64, z_out64;

	// bring inputs to the datapath width
	assign x_in64 = 64'(vec.x_in);
	assign y_in64 = 64'(vec.y_in);

	assign valid_c[0] = vec.valid;
	assign vec.ready  = ready_c[0];
	assign x_c[0]     = x_in64[DATA_WIDTH-1:0];
	assign y_c[0]     = y_in64[DATA_WIDTH-1:0];
	assign z_c[0]     = '0;

	for (genvar i = 0; i < ITERATIONS; i++) begin : g_cell
		cvfp_cell #(
			.DATA_WIDTH      (DATA_WIDTH),
			.IDX             (i),
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (valid_c[i]),
			.up_ready (ready_c[i]),
			.x_d      (x_c[i]),
			.y_d      (y_c[i]),
			.z_d      (z_c[i]),
			.dn_valid (valid_c[i+1]),
			.dn_ready (ready_c[i+1]),
			.x        (x_c[i+1]),
			.y        (y_c[i+1]),
			.z        (z_c[i+1])
		);
	end

	assign ready_c[ITERATIONS] = res.ready;
	assign res.valid           = valid_c[ITERATIONS];

	// sign-extend from the datapath width, then cut to the field
	assign x_out64 = 64'(x_c[ITERATIONS]);
	assign y_out64 = 64'(y_c[ITERATIONS]);
	assign z_out64 = 64'(z_c[ITERATIONS]);

	assign res.x_out     = x_out64[FIELD_W-1:0];
	assign res.y_out     = y_out64[FIELD_W-1:0];
	assign res.angle_out = z_out64[FIELD_W-1:0];
endmodule

// ===== sv/cvfp_cell.sv =====
`timescale 1ns / 1ps
module cvfp_cell #(
	parameter int unsigned DATA_WIDTH      = 32,
	parameter int unsigned IDX             = 0,
	parameter int unsigned ANGLE_FRAC_BITS = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         up_valid,
	output logic                         up_ready,
	input  logic signed [DATA_WIDTH-1:0] x_d,
	input  logic signed [DATA_WIDTH-1:0] y_d,
	input  logic signed [DATA_WIDTH-1:0] z_d,
	output logic                         dn_valid,
	input  logic                         dn_ready,
	output logic signed [DATA_WIDTH-1:0] x,
	output logic signed [DATA_WIDTH-1:0] y,
	output logic signed [DATA_WIDTH-1:0] z
);
	import cvfp_pkg::*;

	localparam logic [63:0]           ANGLE64 = atan_entry(IDX, ANGLE_FRAC_BITS);
	localparam logic [DATA_WIDTH-1:0] ANGLE   = ANGLE64[DATA_WIDTH-1:0];

	logic                         valid_q;
	logic signed [DATA_WIDTH-1:0] x_q, y_q, z_q;
	logic signed [DATA_WIDTH-1:0] xs, ys;
	logic                         pos;
	logic                         load;

	assign xs   = x_d >>> IDX;
	assign ys   = y_d >>> IDX;
	// zero y takes the negative branch
	assign pos  = !y_d[DATA_WIDTH-1] && (y_d != '0);

	assign up_ready = !valid_q || dn_ready;
	assign load     = up_valid && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			if (pos) begin
				x_q <= x_d + ys;
				y_q <= y_d - xs;
				z_q <= z_d + ANGLE;
			end else begin
				x_q <= x_d - ys;
				y_q <= y_d + xs;
				z_q <= z_d - ANGLE;
			end
		end
	end

	assign dn_valid = valid_q;
	assign x        = x_q;
	assign y        = y_q;
	assign z        = z_q;
endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
module tb;
	import cvfp_pkg::*;

	localparam int unsigned ITER         = 15;
	localparam int unsigned FRAC         = 16;
	localparam int unsigned DW           = 32;
	localparam int unsigned RANDOM_ITEMS = 1800;
	localparam int unsigned STALL_LIMIT  = 2000;
	localparam int unsigned N_DIRECTED   = 22;

	typedef logic signed [FIELD_W-1:0] word_t;

	typedef struct {
		word_t x_out;
		word_t y_out;
		word_t angle_out;
	} polar_t;

	typedef struct {
		word_t x;
		word_t y;
		bit    typed;
		word_t ex;
		word_t ey;
		word_t ea;
	} vec_row_t;

	localparam word_t MAXV = 32'h7FFF_FFFF;
	localparam word_t MINV = 32'h8000_0000;
	// origin: y is never positive, so every table entry is subtracted
	localparam word_t ANGLE_AT_ORIGIN = -32'sd114245;

	logic clk;
	logic arst_n;

	cvfp_vec_if vec_ch ();
	cvfp_res_if res_ch ();

	polar_t      polar_q[$];
	polar_t      head;
	word_t       atan_rom[ITER];
	vec_row_t    dir_rows[N_DIRECTED];
	int unsigned fails = 0;
	int unsigned idle_cycles = 0;

	cordic_vectoring_fixed_point_unit #(
		.ITERATIONS     (ITER),
		.DATA_WIDTH     (DW),
		.ANGLE_FRAC_BITS(FRAC)
	) i_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.vec   (vec_ch),
		.res   (res_ch)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// arctangent series at 62 fractional bits, rounded to FRAC bits
	function automatic word_t atan_q(int unsigned i);
		logic [63:0] sum;
		logic [63:0] t;
		int unsigned sh;
		sum = '0;
		if (i == 0) begin
			sum = PI_QUARTER_Q62;
		end else begin
			for (int unsigned n = 0; n < 32; n++) begin
				sh = i * (2 * n + 1);
				if (sh <= 62) begin
					t = (64'd1 << (62 - sh)) / 64'(2 * n + 1);
					if (n % 2 == 1) begin
						sum = sum - t;
					end else begin
						sum = sum + t;
					end
				end
			end
		end
		sum = (sum + (64'd1 << (61 - FRAC))) >> (62 - FRAC);
		return word_t'(sum[31:0]);
	endfunction

	function automatic polar_t cordic_vector(word_t xi, word_t yi);
		polar_t r;
		word_t  x;
		word_t  y;
		word_t  z;
		word_t  xs;
		word_t  ys;
		x = xi;
		y = yi;
		z = '0;
		for (int i = 0; i < ITER; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_rom[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_rom[i];
			end
		end
		r.x_out     = x;
		r.y_out     = y;
		r.angle_out = z;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end
		if (r < 92) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	function automatic void rand_vec(output word_t x, output word_t y);
		case ($urandom_range(0, 9))
			0, 1, 2, 3: begin
				x = $urandom;
				y = $urandom;
			end
			4, 5: begin
				x = $urandom_range(0, 2000) - 1000;
				y = $urandom_range(0, 2000) - 1000;
			end
			6: begin
				x = $urandom;
				y = '0;
			end
			7: begin
				x = $urandom_range(0, 1) ? MAXV - $urandom_range(0, 255)
				                         : MINV + $urandom_range(0, 255);
				y = $urandom;
			end
			8: begin
				x = $urandom;
				y = $urandom_range(0, 32) - 16;
			end
			default: begin
				x = $urandom;
				y = $urandom_range(0, 1) ? x : -x;
			end
		endcase
	endfunction

	task automatic send_vec(word_t x, word_t y, int unsigned gap, bit typed, polar_t want);
		if (gap != 0) begin
			vec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vec_ch.valid <= 1'b1;
		vec_ch.x_in  <= x;
		vec_ch.y_in  <= y;
		@(posedge clk);
		while (!vec_ch.ready) @(posedge clk);
		polar_q.push_back(typed ? want : cordic_vector(x, y));
	endtask

	// hold the sender until every pending result is back
	task automatic drain();
		vec_ch.valid <= 1'b0;
		while (polar_q.size() != 0) @(posedge clk);
	endtask

	initial begin
		word_t  x;
		word_t  y;
		bit     calm;
		polar_t none;
		calm         = 1'b0;
		none         = '{'0, '0, '0};
		arst_n       <= 1'b0;
		vec_ch.valid <= 1'b0;
		vec_ch.x_in  <= '0;
		vec_ch.y_in  <= '0;
		for (int i = 0; i < ITER; i++) begin
			atan_rom[i] = atan_q(i);
		end
		dir_rows = '{
			'{32'sd0, 32'sd0, 1'b1, 32'sd0, 32'sd0, ANGLE_AT_ORIGIN},
			'{MAXV, 32'sd0, 1'b0, 0, 0, 0},
			'{MINV, 32'sd0, 1'b0, 0, 0, 0},
			'{32'sd0, MAXV, 1'b0, 0, 0, 0},
			'{32'sd0, MINV, 1'b0, 0, 0, 0},
			'{MAXV, MAXV, 1'b0, 0, 0, 0},
			'{MINV, MINV, 1'b0, 0, 0, 0},
			'{MAXV, MINV, 1'b0, 0, 0, 0},
			'{MINV, MAXV, 1'b0, 0, 0, 0},
			'{32'sd1, 32'sd0, 1'b0, 0, 0, 0},
			'{-32'sd1, 32'sd0, 1'b0, 0, 0, 0},
			'{32'sd0, 32'sd1, 1'b0, 0, 0, 0},
			'{32'sd0, -32'sd1, 1'b0, 0, 0, 0},
			'{-32'sd1, -32'sd1, 1'b0, 0, 0, 0},
			'{32'sd1, 32'sd1, 1'b0, 0, 0, 0},
			'{32'sd65536, 32'sd65536, 1'b0, 0, 0, 0},
			'{-32'sd65536, 32'sd65536, 1'b0, 0, 0, 0},
			'{32'sd65536, -32'sd65536, 1'b0, 0, 0, 0},
			'{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 0, 0, 0},
			'{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, 0, 0, 0},
			'{32'sd1000, 32'sd1, 1'b0, 0, 0, 0},
			'{-32'sd1000, -32'sd1, 1'b0, 0, 0, 0}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[k]) begin
			send_vec(dir_rows[k].x, dir_rows[k].y, 0, dir_rows[k].typed,
			         '{dir_rows[k].ex, dir_rows[k].ey, dir_rows[k].ea});
		end
		drain();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n % 300 == 0) begin
				calm = ($urandom_range(0, 2) == 0);
			end
			rand_vec(x, y);
			send_vec(x, y, calm ? 0 : pick_gap(), 1'b0, none);
			if ($urandom_range(0, 249) == 0) begin
				drain();
			end
		end
		drain();
		repeat (ITER + 5) @(posedge clk);

		if (fails == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

	// result side: mostly short runs, now and then a long run with no stall
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(60, 200)
			                                  : $urandom_range(1, 8)) @(posedge clk);
			res_ch.ready <= 1'b0;
			repeat (1 + pick_gap()) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				if (polar_q.size() == 0) begin
					$error("result with no vector pending: x_out=%0d y_out=%0d angle_out=%0d",
					       res_ch.x_out, res_ch.y_out, res_ch.angle_out);
					fails++;
				end else begin
					head = polar_q.pop_front();
					if (res_ch.x_out !== head.x_out) begin
						$error("x_out: expected %0d, got %0d", head.x_out, res_ch.x_out);
						fails++;
					end
					if (res_ch.y_out !== head.y_out) begin
						$error("y_out: expected %0d, got %0d", head.y_out, res_ch.y_out);
						fails++;
					end
					if (res_ch.angle_out !== head.angle_out) begin
						$error("angle_out: expected %0d, got %0d",
						       head.angle_out, res_ch.angle_out);
						fails++;
					end
				end
			end
			if ((vec_ch.valid && vec_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				idle_cycles = 0;
			end else begin
				idle_cycles++;
			end
			if (idle_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
sv/cvfp_pkg.sv
sv/cvfp_vec_if.sv
sv/cvfp_res_if.sv
sv/cvfp_cell.sv
sv/cordic_vectoring_fixed_point_unit.sv
tb/sv/tb.sv
